[rtl/core/open_addressing_hash_index_assert.svh]
// Assertion macros used by the open-addressing hash index checker.
`ifndef OPEN_ADDRESSING_HASH_INDEX_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_INDEX_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define OHI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled during reset.
`define OHI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ohi_pkg.sv]
// Shared constants, types and helpers of the open-addressing hash index.
package ohi_pkg;

  localparam int SLOT_COUNT  = 128;
  localparam int ENTRY_COUNT = 128;
  localparam int HASH_BITS   = 32;
  localparam int SLOT_AW     = $clog2(SLOT_COUNT);
  localparam int ENTRY_AW    = $clog2(ENTRY_COUNT);
  localparam int COUNT_W     = $clog2(ENTRY_COUNT + 1);
  localparam int CODE_W      = 9;
  localparam int PCT_W       = 7;
  localparam int IDX_W       = 7;
  localparam int LOAD_W      = 16;

  localparam logic [CODE_W-1:0] CODE_EMPTY   = '0;
  localparam logic [CODE_W-1:0] CODE_DELETED = '1;
  localparam logic [PCT_W-1:0]  LOAD_RESET   = 7'd70;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_ERASE  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    op_t            operation;
    logic [31:0]    hash;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] entry_pos;
    logic             moved;
    logic [IDX_W-1:0] moved_from;
    logic [7:0]       count;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic clear;
    logic init;
    logic step;
    logic found;
    logic ins_write;
    logic set_miss;
    logic set_full;
    logic move_load;
    logic remap_write;
    logic erase_fin;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic load_full;
    logic empty;
    logic deleted;
    logic hash_eq;
    logic code_is_live;
    logic last;
    logic need_move;
    logic out_free;
  } sts_t;

  // First probe step: 1 + hash mod (SLOT_COUNT - 1), by folding 7-bit digits.
  function automatic logic [SLOT_AW-1:0] probe_inc(input logic [HASH_BITS-1:0] h);
    logic [9:0] acc;
    logic [7:0] fold;
    acc = '0;
    for (int i = 0; i < (HASH_BITS + SLOT_AW - 1) / SLOT_AW; i++) begin
      acc = acc + 10'(SLOT_AW'(h >> (SLOT_AW * i)));
    end
    fold = 8'(acc[SLOT_AW-1:0]) + 8'(acc[9:SLOT_AW]);
    if (fold >= 8'(SLOT_COUNT - 1)) begin
      fold = fold - 8'(SLOT_COUNT - 1);
    end
    return SLOT_AW'(fold) + SLOT_AW'(1);
  endfunction

endpackage

[rtl/core/ohi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ohi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/ohi_datapath.sv]
// Datapath of the hash index: slot and entry memories, probe unit and result register.
module ohi_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  ohi_pkg::cmd_t     cmd,
  output ohi_pkg::sts_t     sts,
  input  ohi_pkg::in_item_t in_data,
  input  logic              cfg_valid,
  input  logic [6:0]        cfg_load_percent,
  output logic              out_valid,
  input  logic              out_stall,
  output ohi_pkg::out_item_t out_data
);
  import ohi_pkg::*;

  logic [HASH_BITS-1:0]  hash_r;
  logic [SLOT_AW-1:0]    pos_r;
  logic [SLOT_AW-1:0]    inc_r;
  logic [SLOT_AW-1:0]    n_r;
  logic [SLOT_AW-1:0]    slot_s_r;
  logic [IDX_W-1:0]      k_r;
  logic                  moved_r;
  logic [IDX_W-1:0]      from_r;
  status_t               st_r;
  logic [COUNT_W-1:0]    live_r, live_nxt;
  logic [SLOT_COUNT-1:0] valid_r, valid_nxt;
  logic [PCT_W-1:0]      load_pct_r, load_pct_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r;

  logic [HASH_BITS-1:0]  sh_rdata;
  logic [CODE_W-1:0]     sc_rdata;
  logic [HASH_BITS-1:0]  eh_rdata;
  logic [CODE_W-1:0]     code;
  logic                  sc_we;
  logic [SLOT_AW-1:0]    sc_waddr;
  logic [CODE_W-1:0]     sc_wdata;
  logic                  eh_we;
  logic [ENTRY_AW-1:0]   eh_waddr;
  logic [LOAD_W-1:0]     need_w, lim_w;

  ohi_ram #(.WIDTH(HASH_BITS), .DEPTH(SLOT_COUNT)) u_slot_hash (
    .clk(clk), .we(cmd.ins_write), .waddr(pos_r), .wdata(hash_r),
    .raddr(pos_r), .rdata(sh_rdata)
  );

  ohi_ram #(.WIDTH(CODE_W), .DEPTH(SLOT_COUNT)) u_slot_code (
    .clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
    .raddr(pos_r), .rdata(sc_rdata)
  );

  ohi_ram #(.WIDTH(HASH_BITS), .DEPTH(ENTRY_COUNT)) u_entry_hash (
    .clk(clk), .we(eh_we), .waddr(eh_waddr), .wdata(hash_r),
    .raddr(ENTRY_AW'(live_r - COUNT_W'(1))), .rdata(eh_rdata)
  );

  always_comb begin
    sc_we    = cmd.ins_write | cmd.remap_write | cmd.erase_fin;
    sc_waddr = cmd.erase_fin ? slot_s_r : pos_r;
    if (cmd.ins_write) begin
      sc_wdata = CODE_W'(live_r) + CODE_W'(1);
    end else if (cmd.remap_write) begin
      sc_wdata = CODE_W'(k_r) + CODE_W'(1);
    end else begin
      sc_wdata = CODE_DELETED;
    end
    eh_we    = cmd.ins_write | (cmd.erase_fin & moved_r);
    eh_waddr = cmd.ins_write ? ENTRY_AW'(live_r) : k_r;
  end

  always_comb begin
    code   = valid_r[pos_r] ? sc_rdata : CODE_EMPTY;
    need_w = (LOAD_W'(live_r) + LOAD_W'(2)) * LOAD_W'(100);
    lim_w  = LOAD_W'(SLOT_COUNT) * LOAD_W'(load_pct_r);
    sts.load_full    = (need_w >= lim_w) || (live_r >= COUNT_W'(ENTRY_COUNT));
    sts.empty        = (code == CODE_EMPTY);
    sts.deleted      = (code == CODE_DELETED);
    sts.hash_eq      = (sh_rdata == hash_r);
    sts.code_is_live = (code == CODE_W'(live_r));
    sts.last         = &n_r;
    sts.need_move    = (live_r > COUNT_W'(1)) && (code != CODE_W'(live_r));
    sts.out_free     = !out_valid_r || !out_stall;
  end

  always_comb begin
    live_nxt = live_r;
    valid_nxt = valid_r;
    if (cmd.clear) begin
      live_nxt  = '0;
      valid_nxt = '0;
    end else if (cmd.ins_write) begin
      live_nxt         = live_r + COUNT_W'(1);
      valid_nxt[pos_r] = 1'b1;
    end else if (cmd.erase_fin) begin
      live_nxt = live_r - COUNT_W'(1);
    end
    load_pct_nxt  = cfg_valid ? cfg_load_percent : load_pct_r;
    out_valid_nxt = cmd.publish | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r      <= '0;
      valid_r     <= '0;
      load_pct_r  <= LOAD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      live_r      <= live_nxt;
      valid_r     <= valid_nxt;
      load_pct_r  <= load_pct_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      hash_r  <= in_data.hash;
      k_r     <= '0;
      moved_r <= 1'b0;
      from_r  <= '0;
      st_r    <= ST_OK;
    end
    if (cmd.init) begin
      pos_r <= hash_r[SLOT_AW-1:0];
      inc_r <= probe_inc(hash_r);
      n_r   <= '0;
    end
    if (cmd.step) begin
      pos_r <= pos_r + inc_r;
      inc_r <= inc_r + SLOT_AW'(1);
      n_r   <= n_r + SLOT_AW'(1);
    end
    if (cmd.found) begin
      k_r      <= IDX_W'(code - CODE_W'(1));
      slot_s_r <= pos_r;
    end
    if (cmd.ins_write) begin
      k_r <= IDX_W'(live_r);
    end
    if (cmd.set_miss) begin
      st_r <= ST_MISS;
    end
    if (cmd.set_full) begin
      st_r <= ST_FULL;
    end
    if (cmd.move_load) begin
      hash_r  <= eh_rdata;
      moved_r <= 1'b1;
      from_r  <= IDX_W'(live_r - COUNT_W'(1));
    end
    if (cmd.publish) begin
      out_r.status     <= st_r;
      out_r.entry_pos  <= (st_r == ST_OK) ? k_r : '0;
      out_r.moved      <= moved_r;
      out_r.moved_from <= from_r;
      out_r.count      <= 8'(live_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/core/ohi_ctrl.sv]
// Controller state machine that sequences the probes of each request.
module ohi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ohi_pkg::op_t  in_op,
  input  ohi_pkg::sts_t sts,
  output ohi_pkg::cmd_t cmd
);
  import ohi_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CLEAR = 11'b000_0000_0010,
    S_INIT  = 11'b000_0000_0100,
    S_PRD   = 11'b000_0000_1000,
    S_PEV   = 11'b000_0001_0000,
    S_ERD   = 11'b000_0010_0000,
    S_RINIT = 11'b000_0100_0000,
    S_RRD   = 11'b000_1000_0000,
    S_REV   = 11'b001_0000_0000,
    S_EFIN  = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          op_nxt    = in_op;
          state_nxt = (in_op == OP_CLEAR) ? S_CLEAR : S_INIT;
        end
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = S_DONE;
      end
      S_INIT: begin
        if (op_r == OP_INSERT && sts.load_full) begin
          cmd.set_full = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.init  = 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        state_nxt = S_PEV;
      end
      S_PEV: begin
        if (op_r == OP_INSERT) begin
          if (sts.empty || sts.deleted) begin
            cmd.ins_write = 1'b1;
            state_nxt     = S_DONE;
          end else if (sts.last) begin
            cmd.set_full = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            cmd.step  = 1'b1;
            state_nxt = S_PRD;
          end
        end else if (sts.empty) begin
          cmd.set_miss = 1'b1;
          state_nxt    = S_DONE;
        end else if (sts.hash_eq) begin
          if (sts.deleted) begin
            cmd.set_miss = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            cmd.found = 1'b1;
            if (op_r != OP_ERASE) begin
              state_nxt = S_DONE;
            end else if (sts.need_move) begin
              state_nxt = S_ERD;
            end else begin
              state_nxt = S_EFIN;
            end
          end
        end else if (sts.last) begin
          cmd.set_full = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_ERD: begin
        cmd.move_load = 1'b1;
        state_nxt     = S_RINIT;
      end
      S_RINIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_RRD;
      end
      S_RRD: begin
        state_nxt = S_REV;
      end
      S_REV: begin
        if (sts.empty || sts.last) begin
          state_nxt = S_EFIN;
        end else if (sts.code_is_live) begin
          cmd.remap_write = 1'b1;
          state_nxt       = S_EFIN;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_RRD;
        end
        if (sts.last && sts.code_is_live && !sts.empty) begin
          cmd.remap_write = 1'b1;
        end
      end
      S_EFIN: begin
        cmd.erase_fin = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_LOOKUP;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule

[rtl/core/open_addressing_hash_index.sv]
// Top level of the open-addressing hash index with double-hash probing.
// Each request is handled alone. A clear goes from its clear state straight
// to the done state. Insert, lookup and erase probe slot after slot, and
// every probe reads the slot memories through one registered read port and
// then compares. An erase then retires its slot in a final state, and one
// that moves the last entry first runs a second probe to remap it. A
// finished result waits in the output register while the block returns to
// idle once it is loaded. No clearing pass follows reset.
module open_addressing_hash_index (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ohi_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ohi_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_load_percent
);
  import ohi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ohi_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_op(in_data.operation), .sts(sts), .cmd(cmd)
  );

  ohi_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_data(in_data),
    .cfg_valid(cfg_valid & cfg_ready), .cfg_load_percent(cfg_load_percent),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

[rtl/core/ohi_checker.sv]
// Port-level checker of the hash index and its bind to the top level.
module ohi_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input ohi_pkg::out_item_t out_data
);
  import ohi_pkg::*;
`include "open_addressing_hash_index_assert.svh"

  `OHI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "Result dropped while stalled.")
  `OHI_ASSERT_NOW(a_fail_clean, out_valid && out_data.status != ST_OK, out_data.entry_pos == 0 && !out_data.moved, "Failed request carries an index.")
  `OHI_ASSERT_NOW(a_move_from, out_valid && out_data.moved, out_data.status == ST_OK && 8'(out_data.moved_from) == out_data.count, "Moved entry is not the last one.")
  `OHI_ASSERT_NOW(a_count_max, out_valid, out_data.count <= 8'(ENTRY_COUNT), "Live count exceeds the entry store.")

endmodule

bind open_addressing_hash_index ohi_checker u_ohi_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_data(out_data)
);

[dv/open_addressing_hash_index_test.sv]
// Self-checking testbench of the open-addressing hash index: directed table, then random requests.
module open_addressing_hash_index_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ohi_pkg::*;

  localparam int IDLE_PCT = 22;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 600;
  localparam int RANDOM_ITEMS = 1700;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] cfg_load_percent = 7'd0;

  open_addressing_hash_index dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_load_percent(cfg_load_percent)
  );

  // Shadow copy of the index state.
  logic [31:0] shadow_slot_hash [SLOT_COUNT];
  logic [8:0] shadow_slot_code [SLOT_COUNT];
  logic [31:0] shadow_entry_hash [ENTRY_COUNT];
  int unsigned shadow_live;
  int unsigned shadow_load;

  out_item_t pending_results[$];
  int errors;
  int results_seen;
  int idle_cycles;
  int requests_sent;
  bit quiet;
  bit [3:0] status_seen;
  bit moves_seen;

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("Mismatch on %s: got %0d, expected %0d (result %0d)", what, got, want,
             results_seen);
    errors++;
  endtask

  function automatic status_t find_live(input logic [31:0] h, output int slot);
    int unsigned pos, inc;
    pos = h % SLOT_COUNT;
    inc = 1 + h % (SLOT_COUNT - 1);
    slot = 0;
    for (int n = 0; n < SLOT_COUNT; n++) begin
      if (shadow_slot_code[pos] == CODE_EMPTY) return ST_MISS;
      if (shadow_slot_hash[pos] == h) begin
        if (shadow_slot_code[pos] == CODE_DELETED) return ST_MISS;
        slot = pos;
        return ST_OK;
      end
      pos = (pos + inc) % SLOT_COUNT;
      inc++;
    end
    return ST_FULL;
  endfunction

  function automatic bit find_slot(input logic [31:0] h, input bit want_free,
                                   input logic [8:0] code, output int slot);
    int unsigned pos, inc;
    pos = h % SLOT_COUNT;
    inc = 1 + h % (SLOT_COUNT - 1);
    slot = 0;
    for (int n = 0; n < SLOT_COUNT; n++) begin
      if (want_free) begin
        if (shadow_slot_code[pos] == CODE_EMPTY || shadow_slot_code[pos] == CODE_DELETED) begin
          slot = pos;
          return 1'b1;
        end
      end else begin
        if (shadow_slot_code[pos] == CODE_EMPTY) return 1'b0;
        if (shadow_slot_code[pos] == code) begin
          slot = pos;
          return 1'b1;
        end
      end
      pos = (pos + inc) % SLOT_COUNT;
      inc++;
    end
    return 1'b0;
  endfunction

  function automatic out_item_t apply_request(input in_item_t req);
    out_item_t res;
    int slot, last_slot;
    int unsigned k;
    logic [31:0] last_hash;
    res = '0;
    res.status = ST_OK;
    case (req.operation)
      OP_INSERT: begin
        if ((shadow_live + 2) * 100 >= SLOT_COUNT * shadow_load ||
            shadow_live >= ENTRY_COUNT || !find_slot(req.hash, 1'b1, '0, slot)) begin
          res.status = ST_FULL;
        end else begin
          shadow_entry_hash[shadow_live] = req.hash;
          res.entry_pos = 7'(shadow_live);
          shadow_live++;
          shadow_slot_code[slot] = 9'(shadow_live);
          shadow_slot_hash[slot] = req.hash;
        end
      end
      OP_LOOKUP: begin
        res.status = find_live(req.hash, slot);
        if (res.status == ST_OK) res.entry_pos = 7'(shadow_slot_code[slot] - 9'd1);
      end
      OP_ERASE: begin
        res.status = find_live(req.hash, slot);
        if (res.status == ST_OK) begin
          k = shadow_slot_code[slot] - 1;
          if (shadow_live > 1 && k + 1 != shadow_live) begin
            last_hash = shadow_entry_hash[shadow_live - 1];
            if (find_slot(last_hash, 1'b0, 9'(shadow_live), last_slot)) begin
              shadow_slot_code[last_slot] = 9'(k + 1);
            end
            shadow_entry_hash[k] = last_hash;
            res.moved = 1'b1;
            res.moved_from = 7'(shadow_live - 1);
          end
          if (shadow_live > 0) shadow_live--;
          shadow_slot_code[slot] = CODE_DELETED;
          res.entry_pos = 7'(k);
        end
      end
      default: begin
        foreach (shadow_slot_code[i]) shadow_slot_code[i] = CODE_EMPTY;
        shadow_live = 0;
      end
    endcase
    res.count = 8'(shadow_live);
    return res;
  endfunction

  task automatic send_request(input in_item_t req);
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_request(req));
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_load(input logic [6:0] pct);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_load_percent <= pct;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_load = 32'(pct);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      status_seen[out_data.status] = 1'b1;
      if (out_data.moved) moves_seen = 1'b1;
      if (pending_results.size() == 0) begin
        report_mismatch("outstanding requests", 0, 1);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status != want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.entry_pos != want.entry_pos)
          report_mismatch("entry_pos", out_data.entry_pos, want.entry_pos);
        if (out_data.moved != want.moved)
          report_mismatch("moved", out_data.moved, want.moved);
        if (out_data.moved_from != want.moved_from)
          report_mismatch("moved_from", out_data.moved_from, want.moved_from);
        if (out_data.count != want.count)
          report_mismatch("count", out_data.count, want.count);
      end
    end
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  typedef struct {
    bit is_cfg;
    op_t operation;
    logic [31:0] hash;
    bit typed;
    out_item_t result;
  } step_t;

  step_t directed[] = '{
    '{1'b0, OP_LOOKUP, 32'h0, 1'b1, '{ST_MISS, 7'd0, 1'b0, 7'd0, 8'd0}},
    '{1'b0, OP_ERASE, 32'hFFFF_FFFF, 1'b1, '{ST_MISS, 7'd0, 1'b0, 7'd0, 8'd0}},
    '{1'b0, OP_CLEAR, 32'h0, 1'b1, '{ST_OK, 7'd0, 1'b0, 7'd0, 8'd0}},
    '{1'b0, OP_INSERT, 32'h0, 1'b1, '{ST_OK, 7'd0, 1'b0, 7'd0, 8'd1}},
    '{1'b0, OP_INSERT, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 7'd1, 1'b0, 7'd0, 8'd2}},
    '{1'b0, OP_INSERT, 32'h0, 1'b1, '{ST_OK, 7'd2, 1'b0, 7'd0, 8'd3}},
    '{1'b0, OP_INSERT, 32'h0000_3F80, 1'b0, '0},
    '{1'b0, OP_LOOKUP, 32'h0, 1'b0, '0},
    '{1'b0, OP_ERASE, 32'h0, 1'b0, '0},
    '{1'b0, OP_LOOKUP, 32'h0, 1'b0, '0},
    '{1'b0, OP_LOOKUP, 32'h0000_3F80, 1'b0, '0},
    '{1'b0, OP_ERASE, 32'h0000_3F80, 1'b0, '0},
    '{1'b0, OP_LOOKUP, 32'h0000_3F80, 1'b0, '0},
    '{1'b0, OP_ERASE, 32'hFFFF_FFFF, 1'b0, '0},
    '{1'b0, OP_LOOKUP, 32'h8000_0001, 1'b0, '0},
    '{1'b0, OP_CLEAR, 32'h1234_5678, 1'b1, '{ST_OK, 7'd0, 1'b0, 7'd0, 8'd0}},
    '{1'b1, OP_INSERT, 32'd1, 1'b0, '0},
    '{1'b0, OP_INSERT, 32'h5, 1'b1, '{ST_FULL, 7'd0, 1'b0, 7'd0, 8'd0}},
    '{1'b1, OP_INSERT, 32'd0, 1'b0, '0},
    '{1'b0, OP_INSERT, 32'h5, 1'b1, '{ST_FULL, 7'd0, 1'b0, 7'd0, 8'd0}},
    '{1'b1, OP_INSERT, 32'd127, 1'b0, '0},
    '{1'b0, OP_INSERT, 32'hAAAA_5555, 1'b1, '{ST_OK, 7'd0, 1'b0, 7'd0, 8'd1}},
    '{1'b0, OP_ERASE, 32'hAAAA_5555, 1'b1, '{ST_OK, 7'd0, 1'b0, 7'd0, 8'd0}},
    '{1'b0, OP_LOOKUP, 32'hAAAA_5555, 1'b1, '{ST_MISS, 7'd0, 1'b0, 7'd0, 8'd0}}
  };

  function automatic logic [31:0] pick_hash();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65 && shadow_live > 0)
      return shadow_entry_hash[$urandom_range(shadow_live - 1)];
    if (r < 85)
      return 32'($urandom_range(7)) * 32'd16256 + 32'($urandom_range(3));
    if (r < 88) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  initial begin
    int phase_items;
    int unsigned r;
    logic [6:0] loads [6] = '{7'd100, 7'd127, 7'd1, 7'd45, 7'd70, 7'd0};
    in_item_t req;
    out_item_t got;
    foreach (shadow_slot_code[i]) begin
      shadow_slot_code[i] = CODE_EMPTY;
      shadow_slot_hash[i] = '0;
      shadow_entry_hash[i] = '0;
    end
    shadow_live = 0;
    shadow_load = 32'(LOAD_RESET);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        write_load(7'(directed[i].hash));
      end else begin
        req.operation = directed[i].operation;
        req.hash = directed[i].hash;
        send_request(req);
        if (directed[i].typed) begin
          got = pending_results[$];
          if (got != directed[i].result) begin
            report_mismatch("typed result of a directed row", int'(got),
                            int'(directed[i].result));
          end
        end
      end
    end

    phase_items = RANDOM_ITEMS / $size(loads);
    foreach (loads[p]) begin
      write_load(p == $size(loads) - 1 ? 7'($urandom_range(2, 126)) : loads[p]);
      for (int n = 0; n < phase_items; n++) begin
        quiet = (p == 1);
        r = $urandom_range(99);
        req.operation = r < 45 ? OP_INSERT : r < 70 ? OP_LOOKUP : r < 97 ? OP_ERASE : OP_CLEAR;
        req.hash = pick_hash();
        send_request(req);
      end
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests over %0d load settings; %0d results checked.",
             requests_sent, $size(loads) + 4, results_seen);
    $display("Status codes seen (mask): %b; erases with a move seen: %0d.",
             status_seen[2:0], moves_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
